FILE: rtl/mono_bitmap_colour_expander_assert.svh
// assertion macros for the mono bitmap colour expander
// expects clk and arst_n in the scope of each use
`ifndef MONO_BITMAP_COLOUR_EXPANDER_ASSERT_SVH
`define MONO_BITMAP_COLOUR_EXPANDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MBCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MBCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MBCE_ASSERT_IMP(lbl, ante, cons, msg)
`define MBCE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/mbce_pkg.sv
// shared types and constants of the mono bitmap colour expander
// no dependencies
`default_nettype none
package mbce_pkg;

	localparam int BYTES_PER_HALF_DEF = 4;
	localparam int ROWS_DEF           = 16;
	localparam int QUEUE_DEPTH        = 4;
	localparam int PAT_DEPTH          = 256;
	localparam int PAL_DEPTH          = 16;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_PAT  = 2'd1;
	localparam logic [1:0] OP_PAL  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] MODE_MIRROR   = 2'd0;
	localparam logic [1:0] MODE_UNMIRROR = 2'd1;
	localparam logic [1:0] MODE_OVERDUB  = 2'd2;
	localparam logic [1:0] MODE_PATTERN  = 2'd3;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_COLOUR = 2'd1;
	localparam logic [1:0] CFG_OFFSET = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] fixed_colour;
		logic [3:0]  pattern_offset;
	} cfg_t;

	// one queued command: a bitmap byte or a table load
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic [7:0] idx;
		logic [3:0] pos;
		logic [3:0] row;
		logic       row_end;
		logic       frame_end;
	} qent_t;

	typedef struct packed {
		logic [3:0]  row_number;
		logic [2:0]  group_index;
		logic [31:0] pixel_colour;
		logic [7:0]  pixel_on;
		logic [7:0]  write_enable;
		logic        frame_last;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/mbce_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module mbce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mbce_front.sv
// front end: accepts input beats, tracks byte and row position, queues commands
// depends on mbce_pkg
`default_nettype none
module mbce_front #(
	parameter int BYTES_PER_HALF = mbce_pkg::BYTES_PER_HALF_DEF,
	parameter int ROWS           = mbce_pkg::ROWS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     operation,
	input  wire logic [7:0]     data_byte,
	input  wire logic [7:0]     entry_index,
	output logic                q_push,
	input  wire logic           q_ready,
	output mbce_pkg::qent_t     q_entry
);

	localparam int POSW = (BYTES_PER_HALF > 1) ? $clog2(BYTES_PER_HALF) : 1;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [POSW-1:0] pos_q;
	logic [RW-1:0]   row_q;
	logic            accept;
	logic            row_end;
	logic            frame_end;

	assign in_ready  = q_ready;
	assign accept    = in_valid && q_ready;
	assign q_push    = accept && (operation != mbce_pkg::OP_NONE);
	assign row_end   = (pos_q == POSW'(BYTES_PER_HALF - 1));
	assign frame_end = (row_q == RW'(ROWS - 1));

	always_comb begin
		q_entry.op        = operation;
		q_entry.data      = data_byte;
		q_entry.idx       = entry_index;
		q_entry.pos       = 4'(pos_q);
		q_entry.row       = 4'(row_q);
		q_entry.row_end   = row_end;
		q_entry.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			row_q <= '0;
		end else if (accept && operation == mbce_pkg::OP_BYTE) begin
			if (row_end) begin
				pos_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mbce_fifo.sv
// short command queue between front and back end
// depends on mbce_pkg
`default_nettype none
module mbce_fifo #(
	parameter int DEPTH = mbce_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire mbce_pkg::qent_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output mbce_pkg::qent_t      pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mbce_pkg::qent_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mbce_back.sv
// back end: executes queued commands, replays rows, looks up colours
// depends on mbce_pkg and mbce_ram
`default_nettype none
module mbce_back #(
	parameter int BYTES_PER_HALF = mbce_pkg::BYTES_PER_HALF_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mbce_pkg::cfg_t  cfg,
	input  wire logic            q_valid,
	output logic                 q_ready,
	input  wire mbce_pkg::qent_t q_entry,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output mbce_pkg::res_t       res
);

	localparam int POSW = (BYTES_PER_HALF > 1) ? $clog2(BYTES_PER_HALF) : 1;
	localparam int PAW  = $clog2(mbce_pkg::PAT_DEPTH);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_REPLAY = 1'b1;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	logic            state_q;
	logic [POSW-1:0] k_q;
	logic [3:0]      rep_row_q;
	logic            rep_last_q;
	logic [7:0]      store_q [BYTES_PER_HALF];
	logic [7:0]      pal_q [mbce_pkg::PAL_DEPTH];
	logic [mbce_pkg::PAT_DEPTH-1:0] pat_vld_q;

	logic        vld_s1;
	logic [3:0]  row_s1;
	logic [2:0]  grp_s1;
	logic [7:0]  on_s1;
	logic        last_s1;
	logic        pv_s1;
	logic [3:0]  pat_rd;

	logic        is_byte;
	logic        adv_s1;
	logic        s1_free;
	logic        issue_byte;
	logic        issue_rep;
	logic        issue;
	logic        rep_done;
	logic [4:0]  gsum;
	logic [3:0]  iss_row;
	logic [3:0]  iss_col;
	logic [2:0]  iss_grp;
	logic [7:0]  iss_on;
	logic        iss_last;
	logic [PAW-1:0] iss_addr;
	logic        pat_we;
	logic [3:0]  pal_idx;

	assign is_byte  = (q_entry.op == mbce_pkg::OP_BYTE);
	assign adv_s1   = vld_s1 && (!out_valid || out_ready);
	assign s1_free  = !vld_s1 || adv_s1;
	// loads wait for the colour stage to drain so earlier groups see old tables
	assign q_ready  = (state_q == ST_IDLE) && (is_byte ? s1_free : !vld_s1);
	assign issue_byte = q_valid && q_ready && is_byte;
	assign issue_rep  = (state_q == ST_REPLAY) && s1_free;
	assign issue      = issue_byte || issue_rep;
	assign rep_done   = (k_q == POSW'(BYTES_PER_HALF - 1));
	assign pat_we     = q_valid && q_ready && (q_entry.op == mbce_pkg::OP_PAT);
	assign gsum       = 5'(BYTES_PER_HALF) + 5'(k_q);

	always_comb begin
		if (state_q == ST_REPLAY) begin
			iss_row  = rep_row_q;
			iss_col  = 4'(k_q);
			iss_grp  = gsum[2:0];
			iss_last = rep_done && rep_last_q;
			if (cfg.mode == mbce_pkg::MODE_UNMIRROR) begin
				iss_on = store_q[k_q];
			end else begin
				iss_on = rev8(store_q[POSW'(BYTES_PER_HALF - 1) - k_q]);
			end
		end else begin
			iss_row  = q_entry.row;
			iss_col  = q_entry.pos;
			iss_grp  = q_entry.pos[2:0];
			iss_last = 1'b0;
			iss_on   = q_entry.data;
		end
		iss_addr = {iss_row, iss_col};
	end

	mbce_ram #(
		.WIDTH(4),
		.DEPTH(mbce_pkg::PAT_DEPTH)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (q_entry.idx),
		.wdata (q_entry.data[3:0]),
		.re    (issue),
		.raddr (iss_addr),
		.rdata (pat_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			rep_row_q  <= '0;
			rep_last_q <= 1'b0;
			pat_vld_q  <= '0;
			for (int i = 0; i < mbce_pkg::PAL_DEPTH; i++) begin
				pal_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (issue_byte && q_entry.row_end) begin
						state_q    <= ST_REPLAY;
						k_q        <= '0;
						rep_row_q  <= q_entry.row;
						rep_last_q <= q_entry.frame_end;
					end
				end
				ST_REPLAY: begin
					if (issue_rep) begin
						if (rep_done) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (pat_we) begin
				pat_vld_q[q_entry.idx] <= 1'b1;
			end
			if (q_valid && q_ready && q_entry.op == mbce_pkg::OP_PAL) begin
				pal_q[q_entry.idx[3:0]] <= q_entry.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_byte) begin
			store_q[q_entry.pos[POSW-1:0]] <= q_entry.data;
		end
	end

	// stage 1: group issued, pattern read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (issue) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1  <= iss_row;
			grp_s1  <= iss_grp;
			on_s1   <= iss_on;
			last_s1 <= iss_last;
			pv_s1   <= pat_vld_q[iss_addr];
		end
	end

	// unwritten pattern entries read as zero
	assign pal_idx = cfg.pattern_offset + (pv_s1 ? pat_rd : 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res.row_number   <= row_s1;
			res.group_index  <= grp_s1;
			res.pixel_on     <= on_s1;
			res.frame_last   <= last_s1;
			res.pixel_colour <= (cfg.mode == mbce_pkg::MODE_PATTERN) ?
				{24'd0, pal_q[pal_idx]} : cfg.fixed_colour;
			res.write_enable <= (cfg.mode == mbce_pkg::MODE_OVERDUB) ? on_s1 : 8'hff;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mono_bitmap_colour_expander.sv
// top level of the mono bitmap colour expander: config registers and wiring
// depends on mbce_pkg, mbce_front, mbce_fifo, mbce_back and the assertion header
//
// Bitmap bytes enter row by row; each yields one first-panel group right away,
// and the last byte of a row also yields the row's second-panel groups, one
// group per clock while the output is not stalled. Table loads wait in the back
// end for the colour stage to drain. The back end has a single group issue port
// and a one-read pattern ram, and takes no new command while it replays a row.
// The first group of an accepted beat passes the queue write, the pattern read
// in stage 1 and the output register. The input side keeps accepting while the
// back end replays, up to the four-entry command queue. No clearing pass runs
// after reset.
`default_nettype none
`include "mono_bitmap_colour_expander_assert.svh"
module mono_bitmap_colour_expander #(
	parameter int BYTES_PER_HALF = mbce_pkg::BYTES_PER_HALF_DEF,
	parameter int ROWS           = mbce_pkg::ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  entry_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       row_number,
	output logic [2:0]       group_index,
	output logic [31:0]      pixel_colour,
	output logic [7:0]       pixel_on,
	output logic [7:0]       write_enable,
	output logic             frame_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam logic [2:0] LAST_GRP = 3'((2 * BYTES_PER_HALF) - 1);
	localparam logic [3:0] LAST_ROW = 4'(ROWS - 1);

	mbce_pkg::cfg_t  cfg_q;
	mbce_pkg::qent_t push_ent;
	mbce_pkg::qent_t pop_ent;
	mbce_pkg::res_t  res;
	logic            q_push;
	logic            q_push_ready;
	logic            q_valid;
	logic            q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mbce_pkg::CFG_MODE:   cfg_q.mode           <= cfg_data[1:0];
				mbce_pkg::CFG_COLOUR: cfg_q.fixed_colour   <= cfg_data;
				mbce_pkg::CFG_OFFSET: cfg_q.pattern_offset <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	mbce_front #(
		.BYTES_PER_HALF(BYTES_PER_HALF),
		.ROWS(ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.data_byte   (data_byte),
		.entry_index (entry_index),
		.q_push      (q_push),
		.q_ready     (q_push_ready),
		.q_entry     (push_ent)
	);

	mbce_fifo #(
		.DEPTH(mbce_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push),
		.push_ready (q_push_ready),
		.push_data  (push_ent),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (pop_ent)
	);

	mbce_back #(
		.BYTES_PER_HALF(BYTES_PER_HALF)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_pop),
		.q_entry   (pop_ent),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign row_number   = res.row_number;
	assign group_index  = res.group_index;
	assign pixel_colour = res.pixel_colour;
	assign pixel_on     = res.pixel_on;
	assign write_enable = res.write_enable;
	assign frame_last   = res.frame_last;

	`MBCE_ASSERT_IMP(a_frame_last_pos, out_valid && frame_last,
		(group_index == LAST_GRP) && (row_number == LAST_ROW),
		"frame end flagged away from the last group of the last row")
	`MBCE_ASSERT_IMP(a_we_form, out_valid && (write_enable != 8'hff),
		write_enable == pixel_on, "write enable neither full nor lit pixels")
	`MBCE_ASSERT_IMP(a_full_not_empty, !in_ready, q_valid,
		"input stalled while command queue is empty")
	`MBCE_ASSERT_NXT(a_push_lands,
		in_valid && in_ready && (operation != mbce_pkg::OP_NONE), q_valid,
		"queued beat missing from command queue")

endmodule
`default_nettype wire

FILE: dv/mono_bitmap_colour_expander_tb.sv
// testbench for mono_bitmap_colour_expander: random and directed bitmap bytes and table loads
// depends on mbce_pkg and the rtl top level; a scoreboard class predicts every pixel group
`timescale 1ns / 1ps
`default_nettype none
module mono_bitmap_colour_expander_tb;

	localparam int BYTES_PER_HALF = mbce_pkg::BYTES_PER_HALF_DEF;
	localparam int ROWS           = mbce_pkg::ROWS_DEF;
	localparam int PHASE_ITEMS    = 49;
	localparam int RANDOM_PHASES  = 8;
	localparam int DRAIN_CYCLES   = 12;
	localparam int CYCLE_LIMIT    = 1000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic [7:0]  entry_index;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  row_number;
	logic [2:0]  group_index;
	logic [31:0] pixel_colour;
	logic [7:0]  pixel_on;
	logic [7:0]  write_enable;
	logic        frame_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	mono_bitmap_colour_expander dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.data_byte    (data_byte),
		.entry_index  (entry_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_number   (row_number),
		.group_index  (group_index),
		.pixel_colour (pixel_colour),
		.pixel_on     (pixel_on),
		.write_enable (write_enable),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	class expander_scoreboard;
		logic [1:0]  mode;
		logic [31:0] fixed_colour;
		logic [3:0]  pattern_offset;
		logic [7:0]  row_bytes [BYTES_PER_HALF];
		int          byte_pos;
		int          row_pos;
		logic [3:0]  pattern_tab [mbce_pkg::PAT_DEPTH];
		logic [7:0]  palette_tab [mbce_pkg::PAL_DEPTH];
		mbce_pkg::res_t expected_groups [$];
		int          mismatches;
		int          groups_checked;
		int          frames_seen;
		int          bytes_taken;
		int          loads_taken;

		function new();
			mode = mbce_pkg::MODE_MIRROR;
			fixed_colour = '0;
			pattern_offset = '0;
			byte_pos = 0;
			row_pos = 0;
			mismatches = 0;
			groups_checked = 0;
			frames_seen = 0;
			bytes_taken = 0;
			loads_taken = 0;
			foreach (row_bytes[i]) row_bytes[i] = '0;
			foreach (pattern_tab[i]) pattern_tab[i] = '0;
			foreach (palette_tab[i]) palette_tab[i] = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				mbce_pkg::CFG_MODE:   mode = value[1:0];
				mbce_pkg::CFG_COLOUR: fixed_colour = value;
				mbce_pkg::CFG_OFFSET: pattern_offset = value[3:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] flip_byte(logic [7:0] b);
			logic [7:0] r;
			for (int i = 0; i < 8; i++) r[i] = b[7 - i];
			return r;
		endfunction

		function mbce_pkg::res_t make_group(int grp, int col, logic [7:0] on, bit last);
			mbce_pkg::res_t g;
			logic [3:0]     pat;
			logic [3:0]     pal_idx;
			pat = pattern_tab[{row_pos[3:0], col[3:0]}];
			pal_idx = pattern_offset + pat;
			g.row_number = row_pos[3:0];
			g.group_index = grp[2:0];
			g.pixel_colour = (mode == mbce_pkg::MODE_PATTERN) ?
				{24'h0, palette_tab[pal_idx]} : fixed_colour;
			g.pixel_on = on;
			g.write_enable = (mode == mbce_pkg::MODE_OVERDUB) ? on : 8'hff;
			g.frame_last = last;
			return g;
		endfunction

		function void note_input(logic [1:0] op, logic [7:0] data, logic [7:0] idx);
			bit         last;
			logic [7:0] on;
			case (op)
				mbce_pkg::OP_PAT: begin
					pattern_tab[idx] = data[3:0];
					loads_taken++;
				end
				mbce_pkg::OP_PAL: begin
					palette_tab[idx[3:0]] = data;
					loads_taken++;
				end
				mbce_pkg::OP_BYTE: begin
					bytes_taken++;
					row_bytes[byte_pos] = data;
					expected_groups.push_back(make_group(byte_pos, byte_pos, data, 1'b0));
					if (byte_pos + 1 < BYTES_PER_HALF) begin
						byte_pos++;
					end else begin
						// second panel replays the stored row
						for (int k = 0; k < BYTES_PER_HALF; k++) begin
							last = (k + 1 == BYTES_PER_HALF) && (row_pos + 1 >= ROWS);
							if (mode == mbce_pkg::MODE_UNMIRROR)
								on = row_bytes[k];
							else
								on = flip_byte(row_bytes[BYTES_PER_HALF - 1 - k]);
							expected_groups.push_back(make_group(BYTES_PER_HALF + k, k, on, last));
						end
						byte_pos = 0;
						row_pos = (row_pos + 1) % ROWS;
					end
				end
				default: ;
			endcase
		endfunction

		function void show_group(string tag, mbce_pkg::res_t g);
			$display("  %s: row %0d group %0d colour %h on %h we %h last %0d", tag,
				g.row_number, g.group_index, g.pixel_colour, g.pixel_on,
				g.write_enable, g.frame_last);
		endfunction

		function void check_result(mbce_pkg::res_t got);
			mbce_pkg::res_t want;
			if (expected_groups.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("group with nothing pending at %0t", $realtime);
					show_group("actual", got);
				end
			end else begin
				want = expected_groups.pop_front();
				groups_checked++;
				if (got.frame_last) frames_seen++;
				if (got.row_number !== want.row_number || got.group_index !== want.group_index ||
						got.pixel_colour !== want.pixel_colour || got.pixel_on !== want.pixel_on ||
						got.write_enable !== want.write_enable ||
						got.frame_last !== want.frame_last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("group mismatch at %0t", $realtime);
						show_group("expected", want);
						show_group("actual", got);
					end
				end
			end
		endfunction

		function int failures();
			if (expected_groups.size() != 0)
				$display("%0d expected groups never arrived", expected_groups.size());
			return mismatches + expected_groups.size();
		endfunction
	endclass

	expander_scoreboard sb;
	int cycle_count;
	int stall_left;
	bit feed_quiet;
	bit drain_quiet;
	int phases_run;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({row_number, group_index, pixel_colour, pixel_on,
				write_enable, frame_last});
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// receiver stalls: mostly short, now and then long
	initial begin
		out_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!drain_quiet && $urandom_range(0, 99) < 30) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
					$urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [7:0] data, logic [7:0] idx);
		int gap;
		gap = feed_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= data;
		entry_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, data, idx);
	endtask

	task automatic send_cfg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// stop feeding and let every pending group and table load drain
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.expected_groups.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [1:0] m, logic [31:0] colour, logic [3:0] offset);
		int start;
		start = $urandom_range(0, 2);
		for (int j = 0; j < 3; j++) begin
			case ((start + j) % 3)
				0: send_cfg(mbce_pkg::CFG_MODE, {30'h0, m});
				1: send_cfg(mbce_pkg::CFG_COLOUR, colour);
				default: send_cfg(mbce_pkg::CFG_OFFSET, {28'h0, offset});
			endcase
		end
		phases_run++;
	endtask

	task automatic send_random_item(bit patterned);
		int         r;
		logic [1:0] op;
		logic [7:0] data;
		logic [7:0] idx;
		r = $urandom_range(0, 99);
		data = 8'($urandom_range(0, 255));
		idx = 8'($urandom_range(0, 255));
		if (r < 72) op = mbce_pkg::OP_BYTE;
		else if (r < 84) op = mbce_pkg::OP_PAT;
		else if (r < 95) op = mbce_pkg::OP_PAL;
		else op = mbce_pkg::OP_NONE;
		// aim pattern loads at the columns a panel actually reads
		if (op == mbce_pkg::OP_PAT && patterned && $urandom_range(0, 1))
			idx[3:2] = 2'b00;
		send_item(op, data, idx);
	endtask

	initial begin
		logic [1:0] m;
		sb = new();
		cycle_count = 0;
		phases_run = 0;
		feed_quiet = 1'b0;
		drain_quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = mbce_pkg::OP_NONE;
		data_byte = '0;
		entry_index = '0;
		cfg_valid = 1'b0;
		cfg_index = mbce_pkg::CFG_MODE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: every operation, field extremes, masked indexes and nibbles
		configure(mbce_pkg::MODE_MIRROR, 32'hffff_ffff, 4'h0);
		send_item(mbce_pkg::OP_PAT, 8'hf7, 8'h00);
		send_item(mbce_pkg::OP_PAT, 8'h0a, 8'hff);
		send_item(mbce_pkg::OP_PAL, 8'hff, 8'hf3);
		send_item(mbce_pkg::OP_PAL, 8'h00, 8'h07);
		send_item(mbce_pkg::OP_NONE, 8'hff, 8'hff);
		send_item(mbce_pkg::OP_BYTE, 8'h00, 8'h00);
		send_item(mbce_pkg::OP_BYTE, 8'hff, 8'hff);
		send_item(mbce_pkg::OP_BYTE, 8'h80, 8'h00);
		send_item(mbce_pkg::OP_BYTE, 8'h01, 8'hff);
		settle();

		// directed patterned row with offset wrapping past 15
		configure(mbce_pkg::MODE_PATTERN, 32'h0, 4'hf);
		send_item(mbce_pkg::OP_PAT, 8'hf7, 8'h10);
		send_item(mbce_pkg::OP_PAT, 8'h03, 8'h13);
		send_item(mbce_pkg::OP_PAL, 8'ha5, 8'h06);
		send_item(mbce_pkg::OP_PAL, 8'h3c, 8'h02);
		send_item(mbce_pkg::OP_BYTE, 8'hff, 8'h00);
		send_item(mbce_pkg::OP_BYTE, 8'h00, 8'h00);
		send_item(mbce_pkg::OP_BYTE, 8'haa, 8'h00);
		send_item(mbce_pkg::OP_BYTE, 8'h55, 8'h00);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(mbce_pkg::MODE_UNMIRROR, 32'h0, 4'h0);
				1: configure(mbce_pkg::MODE_OVERDUB, 32'hffff_ffff, 4'hf);
				2: configure(mbce_pkg::MODE_PATTERN, $urandom, 4'h0);
				3: configure(mbce_pkg::MODE_MIRROR, $urandom, 4'hf);
				default: begin
					m = 2'($urandom_range(0, 3));
					configure(m, $urandom, 4'($urandom_range(0, 15)));
				end
			endcase
			feed_quiet = (p == 4) || ($urandom_range(0, 4) == 0);
			drain_quiet = (p == 4) || ($urandom_range(0, 4) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_item(sb.mode == mbce_pkg::MODE_PATTERN);
			settle();
		end

		drain_quiet = 1'b0;
		$display("covered %0d bitmap bytes and %0d table loads over %0d register settings",
			sb.bytes_taken, sb.loads_taken, phases_run);
		$display("checked %0d pixel groups, %0d frame ends, in %0d cycles",
			sb.groups_checked, sb.frames_seen, cycle_count);
		if (sb.failures() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

FILE: mono_bitmap_colour_expander.f
+incdir+rtl
rtl/mbce_pkg.sv
rtl/mbce_ram.sv
rtl/mbce_front.sv
rtl/mbce_fifo.sv
rtl/mbce_back.sv
rtl/mono_bitmap_colour_expander.sv
dv/mono_bitmap_colour_expander_tb.sv
